FILE: hdl/cob_pkg.sv
// Shared types and constants for the cursor overlay blend block.
// Used by cursor_overlay_blend_top; depends on nothing else.
package cob_pkg;

    // Cursor store geometry
    localparam int CURSOR_MAX_SIDE = 64;
    localparam int CSIDE_W         = $clog2(CURSOR_MAX_SIDE);
    localparam int STORE_DEPTH     = CURSOR_MAX_SIDE * CURSOR_MAX_SIDE;
    localparam int STORE_AW        = $clog2(STORE_DEPTH);
    localparam int CWORD_W         = 32;

    // Region geometry
    localparam int REGION_MAX_SIDE = 4096;
    localparam int CNT_W           = $clog2(REGION_MAX_SIDE);

    // Field widths fixed by the interface
    localparam int IDX_W   = 12;
    localparam int COORD_W = 13;
    localparam int POS_W   = 14;
    localparam int SIZE_W  = 7;
    localparam int DIFF_W  = 16;
    localparam int CFGI_W  = 4;
    localparam int CFGD_W  = 14;

    // Reciprocal of 255 in Q23, exact floor for any 16-bit dividend
    localparam logic [15:0] RECIP_255 = 16'd32897;

    // Configuration register indexes
    typedef enum logic [CFGI_W-1:0] {
        CFG_REGION_X      = 4'd0,
        CFG_REGION_Y      = 4'd1,
        CFG_REGION_WIDTH  = 4'd2,
        CFG_REGION_HEIGHT = 4'd3,
        CFG_CURSOR_LEFT   = 4'd4,
        CFG_CURSOR_TOP    = 4'd5,
        CFG_CURSOR_WIDTH  = 4'd6,
        CFG_CURSOR_HEIGHT = 4'd7
    } t_cfg_idx;

    // Item operation codes
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_LOAD  = 1'b1
    } t_op;

    // Per-pixel blend decision
    typedef enum logic [1:0] {
        MODE_KEEP,
        MODE_REPLACE,
        MODE_BLEND
    } t_mode;

    // One input item as it moves through skid and first stage
    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic [CWORD_W-1:0] word;
        logic [7:0]         b0;
        logic [7:0]         b1;
        logic [7:0]         b2;
        logic               last;
    } t_item;

endpackage

FILE: hdl/cob_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module cob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, hold data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/cursor_overlay_blend_top.sv
// Top level of the cursor overlay blend block: skid input, counters, store, blend pipe.
// Depends on cob_pkg and cob_ram.
//
// Takes one item per clock while the output side does not stall, loads and pixels alike,
// and gives one result per frame pixel through stage 1 address at the transfer edge,
// store read, blend product and divide by 255 into the output register. Loads write
// the cursor store from stage 1 through its write port while pixels read it through its
// read port, so a pixel always sees every load that came before it. The store holds no
// reset contents and needs no clearing pass: cursor words must be loaded before a cursor
// is shown. Configuration is taken at any time (ready is always high) but must only
// be written while the block is idle. The input stall is registered: a skid entry
// catches one item when the output side stalls.
module cursor_overlay_blend_top
    import cob_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [IDX_W-1:0]   i_cursor_index,
    input  logic [CWORD_W-1:0] i_cursor_word,
    input  logic [7:0]         i_in_byte0,
    input  logic [7:0]         i_in_byte1,
    input  logic [7:0]         i_in_byte2,
    input  logic               i_frame_last,
    // Result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_byte0,
    output logic [7:0]         o_out_byte1,
    output logic [7:0]         o_out_byte2,
    output logic               o_out_last,
    // Configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFGI_W-1:0]  i_cfg_index,
    input  logic [CFGD_W-1:0]  i_cfg_data
);

    // Configuration registers
    logic [COORD_W-1:0] r_region_x, r_region_y, r_region_w, r_region_h;
    logic [POS_W-1:0]   r_cursor_left, r_cursor_top;
    logic [SIZE_W-1:0]  r_cursor_w, r_cursor_h;

    // Position counters
    logic [CNT_W-1:0] r_col, r_row;
    logic [CNT_W-1:0] n_col, n_row;

    // Skid entry
    logic  r_sk_v;
    t_item r_sk;

    // Stage 1: item and cursor-relative position
    logic              r1_v;
    t_item             r1;
    logic [DIFF_W-1:0] r1_dx, r1_dy;

    // Stage 2: pixel waiting on store data
    logic       r2_v;
    logic       r2_inside;
    logic [7:0] r2_d0, r2_d1, r2_d2;
    logic       r2_last;

    // Stage 3: blend products
    logic       r3_v;
    t_mode      r3_mode;
    logic [7:0] r3_c0, r3_c1, r3_c2;
    logic [7:0] r3_d0, r3_d1, r3_d2;
    logic [15:0] r3_p0, r3_p1, r3_p2;
    logic       r3_last;

    // Output register
    logic       r4_v;
    logic [7:0] r4_b0, r4_b1, r4_b2;
    logic       r4_last;

    logic  en;
    logic  in_xfer;
    logic  src_v;
    t_item src;
    t_item in_item;

    logic [COORD_W-1:0]   rw_clamp, rh_clamp;
    logic [CSIDE_W:0]     cw_clamp, ch_clamp;
    logic [POS_W-1:0]     sx, sy;
    logic                 inside1;
    logic [2*CSIDE_W:0]   addr_full;
    logic                 ram_we, ram_re;
    logic [CWORD_W-1:0]   ram_rdata;
    logic [7:0]           alpha, inv_alpha;
    t_mode                mode2;
    logic [31:0]          q0_full, q1_full, q2_full;

    // Advance the pipe unless the output register is held
    assign en         = !(r4_v && i_out_stall);
    assign o_in_stall = r_sk_v;
    assign in_xfer    = i_in_valid && !r_sk_v;
    assign o_cfg_ready = 1'b1;

    assign in_item = '{op:   t_op'(i_operation),
                       idx:  i_cursor_index,
                       word: i_cursor_word,
                       b0:   i_in_byte0,
                       b1:   i_in_byte1,
                       b2:   i_in_byte2,
                       last: i_frame_last};

    // Pick the item entering stage 1
    assign src_v = r_sk_v || i_in_valid;
    assign src   = r_sk_v ? r_sk : in_item;

    // Clamp sizes
    always_comb begin
        if (r_region_w == '0) begin
            rw_clamp = COORD_W'(1);
        end else if (r_region_w > COORD_W'(REGION_MAX_SIDE)) begin
            rw_clamp = COORD_W'(REGION_MAX_SIDE);
        end else begin
            rw_clamp = r_region_w;
        end
        if (r_region_h == '0) begin
            rh_clamp = COORD_W'(1);
        end else if (r_region_h > COORD_W'(REGION_MAX_SIDE)) begin
            rh_clamp = COORD_W'(REGION_MAX_SIDE);
        end else begin
            rh_clamp = r_region_h;
        end
        if (r_cursor_w > SIZE_W'(CURSOR_MAX_SIDE)) begin
            cw_clamp = (CSIDE_W+1)'(CURSOR_MAX_SIDE);
        end else begin
            cw_clamp = (CSIDE_W+1)'(r_cursor_w);
        end
        if (r_cursor_h > SIZE_W'(CURSOR_MAX_SIDE)) begin
            ch_clamp = (CSIDE_W+1)'(CURSOR_MAX_SIDE);
        end else begin
            ch_clamp = (CSIDE_W+1)'(r_cursor_h);
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_x    <= '0;
            r_region_y    <= '0;
            r_region_w    <= COORD_W'(640);
            r_region_h    <= COORD_W'(480);
            r_cursor_left <= '0;
            r_cursor_top  <= '0;
            r_cursor_w    <= '0;
            r_cursor_h    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REGION_X:      r_region_x    <= i_cfg_data[COORD_W-1:0];
                CFG_REGION_Y:      r_region_y    <= i_cfg_data[COORD_W-1:0];
                CFG_REGION_WIDTH:  r_region_w    <= i_cfg_data[COORD_W-1:0];
                CFG_REGION_HEIGHT: r_region_h    <= i_cfg_data[COORD_W-1:0];
                CFG_CURSOR_LEFT:   r_cursor_left <= i_cfg_data[POS_W-1:0];
                CFG_CURSOR_TOP:    r_cursor_top  <= i_cfg_data[POS_W-1:0];
                CFG_CURSOR_WIDTH:  r_cursor_w    <= i_cfg_data[SIZE_W-1:0];
                CFG_CURSOR_HEIGHT: r_cursor_h    <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Skid entry: catch a transfer while the pipe is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (en) begin
            r_sk_v <= 1'b0;
        end else if (in_xfer) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && in_xfer) begin
            r_sk <= in_item;
        end
    end

    // Advance raster counters per pixel
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (src.last) begin
            n_col = '0;
            n_row = '0;
        end else if (({1'b0, r_col} + COORD_W'(1)) >= rw_clamp) begin
            n_col = '0;
            if (({1'b0, r_row} + COORD_W'(1)) >= rh_clamp) begin
                n_row = '0;
            end else begin
                n_row = r_row + CNT_W'(1);
            end
        end else begin
            n_col = r_col + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (en && src_v && src.op == OP_PIXEL) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1: screen position relative to cursor corner
    assign sx = POS_W'(r_region_x) + POS_W'(r_col);
    assign sy = POS_W'(r_region_y) + POS_W'(r_row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= src_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && src_v) begin
            r1    <= src;
            r1_dx <= DIFF_W'(sx) - {{(DIFF_W-POS_W){r_cursor_left[POS_W-1]}}, r_cursor_left};
            r1_dy <= DIFF_W'(sy) - {{(DIFF_W-POS_W){r_cursor_top[POS_W-1]}}, r_cursor_top};
        end
    end

    // Stage 1: inside test and store address
    assign inside1 = !r1_dx[DIFF_W-1] && !r1_dy[DIFF_W-1]
                     && (r1_dx < DIFF_W'(cw_clamp)) && (r1_dy < DIFF_W'(ch_clamp));
    assign addr_full = r1_dy[CSIDE_W-1:0] * cw_clamp + (2*CSIDE_W+1)'(r1_dx[CSIDE_W-1:0]);

    // Loads write, pixels read, both from stage 1
    assign ram_we = en && r1_v && r1.op == OP_LOAD
                    && ({1'b0, r1.idx} < (IDX_W+1)'(STORE_DEPTH));
    assign ram_re = en && r1_v && r1.op == OP_PIXEL;

    cob_ram #(
        .WIDTH (CWORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r1.idx[STORE_AW-1:0]),
        .i_wdata (r1.word),
        .i_re    (ram_re),
        .i_raddr (addr_full[STORE_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Stage 2: drop loads, carry pixel alongside the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v && r1.op == OP_PIXEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r2_inside <= inside1;
            r2_d0     <= r1.b0;
            r2_d1     <= r1.b1;
            r2_d2     <= r1.b2;
            r2_last   <= r1.last;
        end
    end

    // Stage 2: choose blend mode and form d*(255-a)+127
    assign alpha     = ram_rdata[31:24];
    assign inv_alpha = 8'd255 - alpha;

    always_comb begin
        if (!r2_inside || alpha == 8'd0) begin
            mode2 = MODE_KEEP;
        end else if (alpha == 8'd255) begin
            mode2 = MODE_REPLACE;
        end else begin
            mode2 = MODE_BLEND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r2_v) begin
            r3_mode <= mode2;
            r3_c0   <= ram_rdata[7:0];
            r3_c1   <= ram_rdata[15:8];
            r3_c2   <= ram_rdata[23:16];
            r3_d0   <= r2_d0;
            r3_d1   <= r2_d1;
            r3_d2   <= r2_d2;
            r3_p0   <= 16'(r2_d0) * 16'(inv_alpha) + 16'd127;
            r3_p1   <= 16'(r2_d1) * 16'(inv_alpha) + 16'd127;
            r3_p2   <= 16'(r2_d2) * 16'(inv_alpha) + 16'd127;
            r3_last <= r2_last;
        end
    end

    // Stage 3: divide by 255 through the reciprocal, add cursor channel
    assign q0_full = 32'(r3_p0) * 32'(RECIP_255);
    assign q1_full = 32'(r3_p1) * 32'(RECIP_255);
    assign q2_full = 32'(r3_p2) * 32'(RECIP_255);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r3_v) begin
            r4_last <= r3_last;
            case (r3_mode)
                MODE_REPLACE: begin
                    r4_b0 <= r3_c0;
                    r4_b1 <= r3_c1;
                    r4_b2 <= r3_c2;
                end
                MODE_BLEND: begin
                    r4_b0 <= r3_c0 + q0_full[30:23];
                    r4_b1 <= r3_c1 + q1_full[30:23];
                    r4_b2 <= r3_c2 + q2_full[30:23];
                end
                default: begin
                    r4_b0 <= r3_d0;
                    r4_b1 <= r3_d1;
                    r4_b2 <= r3_d2;
                end
            endcase
        end
    end

    assign o_out_valid = r4_v;
    assign o_out_byte0 = r4_b0;
    assign o_out_byte1 = r4_b1;
    assign o_out_byte2 = r4_b2;
    assign o_out_last  = r4_last;

    // Skid fills only while the pipe is held
    a_skid_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_v) |-> $past(!en))
        else $error("skid entry filled while pipe advanced");

    // Store is never written and read by the same stage-1 item
    a_store_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store write and read issued together");

    // Opaque cursor pixel replaces the frame channel
    a_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r3_v && r3_mode == MODE_REPLACE) |=> (o_out_byte0 == $past(r3_c0)))
        else $error("opaque pixel not replaced");

endmodule
